// ----- design/hidp_pkg.sv -----
package hidp_pkg;

    localparam int USAGE_DEPTH_DEF      = 16;
    localparam int COLLECTION_DEPTH_DEF = 8;
    localparam int PUSH_DEPTH_DEF       = 4;
    localparam int MAX_RESULTS          = 16;

    localparam logic [7:0] TAG_MASK  = 8'hfc;
    localparam logic [7:0] TYPE_MASK = 8'h0c;
    localparam logic [7:0] SIZE_MASK = 8'h03;
    localparam logic [7:0] APP_CODE  = 8'h01;

    localparam logic [7:0] TAG_INPUT     = 8'h80;
    localparam logic [7:0] TAG_OUTPUT    = 8'h90;
    localparam logic [7:0] TAG_FEATURE   = 8'hb0;
    localparam logic [7:0] TAG_COLL      = 8'ha0;
    localparam logic [7:0] TAG_END_COLL  = 8'hc0;
    localparam logic [7:0] TAG_PAGE      = 8'h04;
    localparam logic [7:0] TAG_RSIZE     = 8'h74;
    localparam logic [7:0] TAG_RCOUNT    = 8'h94;
    localparam logic [7:0] TAG_LMIN      = 8'h14;
    localparam logic [7:0] TAG_LMAX      = 8'h24;
    localparam logic [7:0] TAG_RID       = 8'h84;
    localparam logic [7:0] TAG_PUSH      = 8'ha4;
    localparam logic [7:0] TAG_POP       = 8'hb4;
    localparam logic [7:0] TAG_USAGE     = 8'h08;
    localparam logic [7:0] TAG_USAGE_MIN = 8'h18;
    localparam logic [7:0] TAG_USAGE_MAX = 8'h28;

    localparam logic [1:0] RTYPE_INPUT   = 2'd0;
    localparam logic [1:0] RTYPE_OUTPUT  = 2'd1;
    localparam logic [1:0] RTYPE_FEATURE = 2'd2;

    // complete item handed from the byte assembler to the executor
    typedef struct packed {
        logic [7:0]  prefix;
        logic [31:0] value;
        logic        last;
    } hidp_item_t;

    function automatic logic [2:0] item_len(input logic [7:0] p);
        logic [1:0] c;
        c = p[1:0] & SIZE_MASK[1:0];
        return (c == 2'd3) ? 3'd4 : {1'b0, c};
    endfunction

endpackage

// ----- design/hidp_front.sv -----
module hidp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               item_valid,
    input  logic               item_ready,
    output hidp_pkg::hidp_item_t item,
    output logic               item_real
);
    import hidp_pkg::*;

    logic [2:0]  remain_reg, remain_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  pos;
    logic        emit;
    logic        accept;

    assign in_ready = item_ready;
    assign accept   = in_valid && in_ready;
    assign pos      = 2'(item_len(prefix_reg) - remain_reg);

    always_comb
    begin
        remain_next = remain_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        emit        = 1'b0;
        item.prefix = prefix_reg;
        item.value  = acc_reg;
        item.last   = last_byte;
        if (remain_reg == 3'd0)
        begin
            if (item_len(data_byte) == 3'd0)
            begin
                emit        = 1'b1;
                item.prefix = data_byte;
                item.value  = '0;
            end
            else
            begin
                prefix_next = data_byte;
                acc_next    = '0;
                remain_next = item_len(data_byte);
            end
        end
        else
        begin
            acc_next    = acc_reg | (32'(data_byte) << {pos, 3'b000});
            remain_next = remain_reg - 3'd1;
            item.value  = acc_next;
            emit        = (remain_next == 3'd0);
        end
        // an item that is not complete at the last byte is dropped
        if (last_byte)
        begin
            remain_next = '0;
            prefix_next = '0;
            acc_next    = '0;
        end
    end

    // the final byte always travels so the back end resets its state
    assign item_valid = in_valid && (emit || last_byte);
    assign item_real  = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            prefix_reg <= '0;
            acc_reg    <= '0;
        end
        else if (accept)
        begin
            remain_reg <= remain_next;
            prefix_reg <= prefix_next;
            acc_reg    <= acc_next;
        end
    end
endmodule

// ----- design/hidp_queue.sv -----
module hidp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  hidp_pkg::hidp_item_t wr_item,
    input  logic                 wr_real,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output hidp_pkg::hidp_item_t rd_item,
    output logic                 rd_real
);
    import hidp_pkg::*;

    // two-entry queue
    hidp_item_t  mem_reg [2];
    logic [1:0]  real_reg;
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rp_reg];
    assign rd_real  = real_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= '0;
            real_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg           <= ~wp_reg;
                real_reg[wp_reg] <= wr_real;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

// ----- design/hidp_back.sv -----
module hidp_back
#(
    parameter int USAGE_DEPTH      = hidp_pkg::USAGE_DEPTH_DEF,
    parameter int COLLECTION_DEPTH = hidp_pkg::COLLECTION_DEPTH_DEF,
    parameter int PUSH_DEPTH       = hidp_pkg::PUSH_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hidp_pkg::hidp_item_t item,
    input  logic                 item_real,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [1:0]           report_type,
    output logic [15:0]          field_page,
    output logic [15:0]          usage_id,
    output logic                 usage_valid,
    output logic [7:0]           field_bits,
    output logic [7:0]           field_count,
    output logic signed [31:0]   lim_low,
    output logic signed [31:0]   lim_high,
    output logic [7:0]           rep_id,
    output logic                 last_of_run
);
    import hidp_pkg::*;

    localparam int UW = $clog2(USAGE_DEPTH + 1);
    localparam int UI = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;
    localparam int CW = $clog2(COLLECTION_DEPTH + 1);
    localparam int CI = (COLLECTION_DEPTH > 1) ? $clog2(COLLECTION_DEPTH) : 1;
    localparam int PW = $clog2(PUSH_DEPTH + 1);
    localparam int PI = (PUSH_DEPTH > 1) ? $clog2(PUSH_DEPTH) : 1;
    localparam int EW = (USAGE_DEPTH < MAX_RESULTS) ? USAGE_DEPTH : MAX_RESULTS;
    localparam int NW = $clog2(EW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_RANG = 2'd2;

    logic [1:0]  state_reg;
    logic [15:0] page_reg;
    logic [7:0]  rsize_reg, rcount_reg, rid_reg;
    logic [31:0] lmin_reg, lmax_reg;
    logic [PW-1:0] push_reg;
    logic [UW-1:0] fill_reg;
    logic [CW-1:0] coll_reg;
    logic        app_reg;
    logic        hold_reg;

    logic [103:0] push_mem [PUSH_DEPTH];
    logic [15:0]  usage_mem [USAGE_DEPTH];
    logic [32:0]  coll_mem [COLLECTION_DEPTH];
    logic [15:0]  last_usage_reg;

    // field emission walk
    logic [NW-1:0] emit_n_reg, emit_i_reg;
    logic [1:0]    emit_type_reg;
    logic          emit_last_reg;
    // usage max range expansion
    logic [16:0]   rng_u_reg;
    logic [31:0]   rng_max_reg;

    // output register
    logic        ov_reg;
    logic        o_kind_reg, o_uval_reg, o_last_reg;
    logic [1:0]  o_type_reg;
    logic [15:0] o_page_reg, o_uid_reg;
    logic [7:0]  o_size_reg, o_count_reg, o_rid_reg;
    logic [31:0] o_lmin_reg, o_lmax_reg;

    logic        out_free;
    logic        take;
    logic [7:0]  tag;
    logic [1:0]  sz;
    logic [31:0] sval;
    logic [15:0] top_usage;
    logic [32:0] coll_top_reg;
    logic [103:0] push_top_reg;

    assign out_free   = !ov_reg || out_ready;
    // after each item, hold off the next one until the stack tops are read back
    assign item_ready = (state_reg == ST_IDLE) && out_free && !hold_reg;
    assign take       = item_valid && item_ready;
    assign tag        = item.prefix & TAG_MASK;
    assign sz         = item.prefix[1:0] & SIZE_MASK[1:0];
    assign top_usage  = last_usage_reg;

    always_comb
    begin
        case (sz)
            2'd1:    sval = {{24{item.value[7]}}, item.value[7:0]};
            2'd2:    sval = {{16{item.value[15]}}, item.value[15:0]};
            default: sval = item.value;
        endcase
    end

    assign out_valid    = ov_reg;
    assign result_kind  = o_kind_reg;
    assign report_type  = o_type_reg;
    assign field_page   = o_page_reg;
    assign usage_id     = o_uid_reg;
    assign usage_valid  = o_uval_reg;
    assign field_bits   = o_size_reg;
    assign field_count  = o_count_reg;
    assign lim_low      = o_lmin_reg;
    assign lim_high     = o_lmax_reg;
    assign rep_id       = o_rid_reg;
    assign last_of_run  = o_last_reg;

    always_ff @(posedge clk)
    begin
        coll_top_reg <= coll_mem[CI'(coll_reg - CW'(1))];
        push_top_reg <= push_mem[PI'(push_reg - PW'(1))];
        if (take && item_real && tag == TAG_PUSH && push_reg < PW'(PUSH_DEPTH))
        begin
            push_mem[PI'(push_reg)] <= {lmax_reg[31:0], rid_reg, lmin_reg,
                                        rcount_reg, rsize_reg, page_reg};
        end
        if (take && item_real && tag == TAG_COLL && coll_reg < CW'(COLLECTION_DEPTH))
        begin
            coll_mem[CI'(coll_reg)] <= {(item.value[7:0] == APP_CODE),
                                        (fill_reg != '0) ? top_usage : 16'd0, page_reg};
        end
        if (take && item_real && (tag == TAG_USAGE || tag == TAG_USAGE_MIN)
            && fill_reg < UW'(USAGE_DEPTH))
        begin
            usage_mem[UI'(fill_reg)] <= item.value[15:0];
            last_usage_reg           <= item.value[15:0];
        end
        if (state_reg == ST_RANG && fill_reg < UW'(USAGE_DEPTH)
            && {15'd0, rng_u_reg} <= rng_max_reg)
        begin
            usage_mem[UI'(fill_reg)] <= rng_u_reg[15:0];
            last_usage_reg           <= rng_u_reg[15:0];
        end
        if (out_free)
        begin
            o_kind_reg  <= 1'b0;
            o_type_reg  <= emit_type_reg;
            o_page_reg  <= page_reg;
            o_uid_reg   <= '0;
            o_uval_reg  <= 1'b0;
            o_size_reg  <= rsize_reg;
            o_count_reg <= rcount_reg;
            o_lmin_reg  <= lmin_reg;
            o_lmax_reg  <= lmax_reg;
            o_rid_reg   <= rid_reg;
            o_last_reg  <= 1'b1;
            if (state_reg == ST_EMIT)
            begin
                o_uid_reg  <= usage_mem[UI'(emit_i_reg)];
                o_uval_reg <= 1'b1;
                o_last_reg <= (emit_i_reg == emit_n_reg - NW'(1));
            end
            else if (take && tag == TAG_END_COLL)
            begin
                o_kind_reg  <= 1'b1;
                o_type_reg  <= RTYPE_INPUT;
                o_page_reg  <= coll_top_reg[15:0];
                o_uid_reg   <= coll_top_reg[31:16];
                o_size_reg  <= '0;
                o_count_reg <= '0;
                o_lmin_reg  <= '0;
                o_lmax_reg  <= '0;
            end
            else if (take)
            begin
                o_type_reg <= (tag == TAG_INPUT) ? RTYPE_INPUT :
                              (tag == TAG_OUTPUT) ? RTYPE_OUTPUT : RTYPE_FEATURE;
            end
        end
    end

    logic is_field;
    assign is_field = (tag == TAG_INPUT) || (tag == TAG_OUTPUT) || (tag == TAG_FEATURE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            page_reg      <= '0;
            rsize_reg     <= '0;
            rcount_reg    <= '0;
            rid_reg       <= '0;
            lmin_reg      <= '0;
            lmax_reg      <= '0;
            push_reg      <= '0;
            fill_reg      <= '0;
            coll_reg      <= '0;
            app_reg       <= 1'b0;
            hold_reg      <= 1'b0;
            ov_reg        <= 1'b0;
            emit_n_reg    <= '0;
            emit_i_reg    <= '0;
            emit_type_reg <= '0;
            emit_last_reg <= 1'b0;
            rng_u_reg     <= '0;
            rng_max_reg   <= '0;
        end
        else
        begin
            hold_reg <= take;
            if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take && item_real)
                    begin
                        if (is_field && app_reg)
                        begin
                            emit_type_reg <= (tag == TAG_INPUT) ? RTYPE_INPUT :
                                (tag == TAG_OUTPUT) ? RTYPE_OUTPUT : RTYPE_FEATURE;
                            if (fill_reg == '0)
                            begin
                                ov_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg     <= ST_EMIT;
                                emit_i_reg    <= '0;
                                emit_n_reg    <= (fill_reg > UW'(EW)) ? NW'(EW) : NW'(fill_reg);
                                emit_last_reg <= item.last;
                            end
                        end
                        case (tag)
                            TAG_COLL:
                            begin
                                if (coll_reg < CW'(COLLECTION_DEPTH))
                                begin
                                    coll_reg <= coll_reg + CW'(1);
                                    if (item.value[7:0] == APP_CODE)
                                    begin
                                        app_reg <= 1'b1;
                                    end
                                end
                            end
                            TAG_END_COLL:
                            begin
                                if (coll_reg != '0)
                                begin
                                    coll_reg <= coll_reg - CW'(1);
                                    if (coll_top_reg[32])
                                    begin
                                        ov_reg <= 1'b1;
                                    end
                                end
                            end
                            TAG_PAGE:   page_reg   <= item.value[15:0];
                            TAG_RSIZE:  rsize_reg  <= item.value[7:0];
                            TAG_RCOUNT: rcount_reg <= item.value[7:0];
                            TAG_LMIN:   lmin_reg   <= sval;
                            TAG_LMAX:   lmax_reg   <= sval;
                            TAG_RID:    rid_reg    <= item.value[7:0];
                            TAG_PUSH:
                            begin
                                if (push_reg < PW'(PUSH_DEPTH))
                                begin
                                    push_reg <= push_reg + PW'(1);
                                end
                            end
                            TAG_POP:
                            begin
                                if (push_reg != '0)
                                begin
                                    push_reg   <= push_reg - PW'(1);
                                    page_reg   <= push_top_reg[15:0];
                                    rsize_reg  <= push_top_reg[23:16];
                                    rcount_reg <= push_top_reg[31:24];
                                    lmin_reg   <= push_top_reg[63:32];
                                    rid_reg    <= push_top_reg[71:64];
                                    lmax_reg   <= push_top_reg[103:72];
                                end
                            end
                            TAG_USAGE, TAG_USAGE_MIN:
                            begin
                                if (fill_reg < UW'(USAGE_DEPTH))
                                begin
                                    fill_reg <= fill_reg + UW'(1);
                                end
                            end
                            TAG_USAGE_MAX:
                            begin
                                if (fill_reg != '0 && fill_reg < UW'(USAGE_DEPTH))
                                begin
                                    state_reg   <= ST_RANG;
                                    rng_u_reg   <= {1'b0, top_usage} + 17'd1;
                                    rng_max_reg <= item.value;
                                end
                            end
                            default: ;
                        endcase
                        // main items clear the usage list; emission reads it first
                        if ((item.prefix & TYPE_MASK) == 8'h00 && !(is_field && app_reg
                            && fill_reg != '0))
                        begin
                            fill_reg <= '0;
                        end
                    end
                    if (take && item.last && !(item_real && is_field && app_reg
                        && fill_reg != '0) && !(item_real && tag == TAG_USAGE_MAX))
                    begin
                        page_reg <= '0; rsize_reg <= '0; rcount_reg <= '0;
                        rid_reg <= '0; lmin_reg <= '0; lmax_reg <= '0;
                        push_reg <= '0; fill_reg <= '0; coll_reg <= '0;
                        app_reg <= 1'b0;
                    end
                    else if (take && item.last && item_real && tag == TAG_USAGE_MAX)
                    begin
                        page_reg <= '0; rsize_reg <= '0; rcount_reg <= '0;
                        rid_reg <= '0; lmin_reg <= '0; lmax_reg <= '0;
                        push_reg <= '0; fill_reg <= '0; coll_reg <= '0;
                        app_reg <= 1'b0; state_reg <= ST_IDLE;
                    end
                    else if (take && item.last && is_field && app_reg)
                    begin
                        // reset after emission walk
                        page_reg <= page_reg;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg     <= 1'b1;
                        emit_i_reg <= emit_i_reg + NW'(1);
                        if (emit_i_reg == emit_n_reg - NW'(1))
                        begin
                            state_reg <= ST_IDLE;
                            fill_reg  <= '0;
                            if (emit_last_reg)
                            begin
                                page_reg <= '0; rsize_reg <= '0; rcount_reg <= '0;
                                rid_reg <= '0; lmin_reg <= '0; lmax_reg <= '0;
                                push_reg <= '0; coll_reg <= '0; app_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_RANG:
                begin
                    if (fill_reg < UW'(USAGE_DEPTH) && {15'd0, rng_u_reg} <= rng_max_reg)
                    begin
                        fill_reg  <= fill_reg + UW'(1);
                        rng_u_reg <= rng_u_reg + 17'd1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- design/hid_report_descriptor_parser_unit.sv -----
// HID report descriptor parser.
// Input channel: one descriptor byte per transfer (data_byte, last_byte) on
// in_valid/in_ready. Output channel: one result per transfer on out_valid/out_ready,
// with last_of_run high on the final result caused by a byte.
// A byte assembler collects prefix and value bytes into items and hands them
// through a two-entry queue to an executor that holds the global, push, usage
// and collection state. A value byte that does not complete an item stays in the
// assembler. The executor takes a complete item from the queue when idle and then
// holds off until its stack tops are read, so it never takes items back to back.
// A closure result or a field without usages is written to the output register
// as the executor takes the item; a field with usages gives its results in the
// emission walk that follows, one per cycle while the output register is free,
// up to 16. A Usage Max range adds one usage per cycle. The byte flagged last_byte
// returns all parser state to its reset values. Reset clears all control state
// and leaves the stacks unwritten. When the receiver stalls, the output register
// holds its result, the executor stops, the queue fills and in_ready drops.
module hid_report_descriptor_parser_unit
#(
    parameter int USAGE_DEPTH      = hidp_pkg::USAGE_DEPTH_DEF,
    parameter int COLLECTION_DEPTH = hidp_pkg::COLLECTION_DEPTH_DEF,
    parameter int PUSH_DEPTH       = hidp_pkg::PUSH_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [1:0]         report_type,
    output logic [15:0]        field_page,
    output logic [15:0]        usage_id,
    output logic               usage_valid,
    output logic [7:0]         field_bits,
    output logic [7:0]         field_count,
    output logic signed [31:0] lim_low,
    output logic signed [31:0] lim_high,
    output logic [7:0]         rep_id,
    output logic               last_of_run
);
    import hidp_pkg::*;

    hidp_item_t f_item, q_item;
    logic       f_valid, f_ready, q_valid, q_ready, q_real;
    // high when the transfer carries a complete item, low for a bare reset mark
    logic       f_real;

    hidp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item),
        .item_real  (f_real)
    );

    hidp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .wr_real  (f_real),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item),
        .rd_real  (q_real)
    );

    hidp_back
    #(
        .USAGE_DEPTH      (USAGE_DEPTH),
        .COLLECTION_DEPTH (COLLECTION_DEPTH),
        .PUSH_DEPTH       (PUSH_DEPTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (q_valid),
        .item_ready   (q_ready),
        .item         (q_item),
        .item_real    (q_real),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .report_type  (report_type),
        .field_page   (field_page),
        .usage_id     (usage_id),
        .usage_valid  (usage_valid),
        .field_bits   (field_bits),
        .field_count  (field_count),
        .lim_low      (lim_low),
        .lim_high     (lim_high),
        .rep_id       (rep_id),
        .last_of_run  (last_of_run)
    );
endmodule
